// File: design/nirfd_pkg.sv
// ----------------------------------------------------------------------------
// nirfd_pkg
// Shared types and constants of the NEC infrared frame decoder: field
// widths, pulse timing targets, frame positions, register reset values and indexes.
// ----------------------------------------------------------------------------
package nirfd_pkg;

   localparam int unsigned TICKS_W     = 15;
   localparam int unsigned WORD_W      = 16;
   localparam int unsigned MARGIN_W    = 10;
   localparam int unsigned US_W        = 14;
   localparam int unsigned POS_W       = 6;
   localparam int unsigned BIT_IDX_W   = 4;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 10;

   localparam logic [US_W-1:0] HDR_MARK_US   = 14'd9000;
   localparam logic [US_W-1:0] HDR_SPACE_US  = 14'd4500;
   localparam logic [US_W-1:0] BIT_MARK_US   = 14'd560;
   localparam logic [US_W-1:0] ONE_SPACE_US  = 14'd1690;
   localparam logic [US_W-1:0] ZERO_SPACE_US = 14'd560;

   localparam int unsigned US_PER_10US = 10;

   localparam logic [POS_W-1:0] POS_HEADER    = 6'd0;
   localparam logic [POS_W-1:0] POS_LAST_ADDR = 6'd16;
   localparam logic [POS_W-1:0] POS_FIRST_CMD = 6'd17;
   localparam logic [POS_W-1:0] POS_LAST_BIT  = 6'd32;
   localparam logic [POS_W-1:0] FRAME_ITEMS   = 6'd34;

   localparam logic                ACTIVE_LEVEL_RESET = 1'b1;
   localparam logic [MARGIN_W-1:0] TOLERANCE_RESET    = 10'd20;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ACTIVE_LEVEL = 1'b0,
      CSR_TOLERANCE    = 1'b1
   } csr_index_type;

endpackage

// File: design/nirfd_ifs.sv
// ----------------------------------------------------------------------------
// nirfd_ifs
// Valid/ready channels of the NEC infrared frame decoder: the pulse item
// channel and the decoded frame channel.
// ----------------------------------------------------------------------------
interface nirfd_req_if import nirfd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               first_level;
   logic [TICKS_W-1:0] first_ticks;
   logic               second_level;
   logic [TICKS_W-1:0] second_ticks;
   logic               last_item;

   modport source (
      output valid, first_level, first_ticks, second_level, second_ticks, last_item,
      input  ready
   );
   modport sink (
      input  valid, first_level, first_ticks, second_level, second_ticks, last_item,
      output ready
   );
endinterface

interface nirfd_rsp_if import nirfd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              frame_valid;
   logic [WORD_W-1:0] address;
   logic [WORD_W-1:0] command;

   modport source (
      output valid, frame_valid, address, command,
      input  ready
   );
   modport sink (
      input  valid, frame_valid, address, command,
      output ready
   );
endinterface

// File: design/nec_ir_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_core
// Decodes NEC infrared frames from pulse items (mark/space level and duration
// in ticks). One header item, 32 data bits LSB first (address, then command).
//
// req_chan carries one pulse item per handshake; last_item closes the buffer.
// rsp_chan carries one frame item (frame_valid, address, command) for every
// item with last_item set; address and command are zero on a bad frame.
// csr_* writes active_level (index 0) and tolerance (index 1).
//
// An item is held in an input register, then checked against the timing
// windows and folded into the frame state on the next edge; the frame item
// of a last item goes from the input register to the output register. One
// item is accepted per cycle unless stalled. A waiting frame item stalls only
// a following last item; other items keep flowing while rsp_chan is held.
// Reset clears the frame state and both channels and restores the registers
// to active_level 1 and tolerance 20.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_core import nirfd_pkg::*; #(
   parameter int unsigned TICKS_PER_10US = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   nirfd_req_if.sink              req_chan,
   nirfd_rsp_if.source            rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int unsigned CMP_W = 20 + $clog2(TICKS_PER_10US);

   // duration in ticks*10 checked against (target +- margin) us scaled by ticks per 10 us
   function automatic logic near_target(input logic [CMP_W-1:0]    scaled,
                                        input logic [US_W-1:0]     target,
                                        input logic [MARGIN_W-1:0] margin);
      logic [CMP_W-1:0] hi_bound;
      logic [CMP_W-1:0] lo_bound;
      logic             lo_ok;
      hi_bound = (CMP_W'(target) + CMP_W'(margin)) * CMP_W'(TICKS_PER_10US);
      lo_bound = (CMP_W'(target) - CMP_W'(margin) + CMP_W'(1)) * CMP_W'(TICKS_PER_10US);
      lo_ok    = (US_W'(margin) > target) || (scaled >= lo_bound);
      return (scaled < hi_bound) && lo_ok;
   endfunction

   // configuration
   logic                active_level_ff, active_level_in;
   logic [MARGIN_W-1:0] margin_ff, margin_in;

   // input register
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_first_level_ff, s1_second_level_ff, s1_last_ff;
   logic [TICKS_W-1:0] s1_first_ticks_ff, s1_second_ticks_ff;

   // frame state
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [WORD_W-1:0] addr_ff, addr_in;
   logic [WORD_W-1:0] cmd_ff, cmd_in;
   logic              err_ff, err_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_frame_valid_ff;
   logic [WORD_W-1:0] rsp_address_ff, rsp_command_ff;

   logic              req_fire, s1_fire, rsp_load;
   logic [CMP_W-1:0]  scaled0, scaled1;
   logic              levels_ok, hdr_ok, one_ok, zero_ok, bit_val;
   logic              in_header, in_bits, in_addr, item_err;
   logic [BIT_IDX_W-1:0] addr_idx, cmd_idx;
   logic [POS_W-1:0]  pos_next;
   logic [WORD_W-1:0] addr_next, cmd_next;
   logic              err_next, frame_ok;

   assign s1_fire  = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_fire;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_load = s1_fire && s1_last_ff;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.frame_valid = rsp_frame_valid_ff;
   assign rsp_chan.address     = rsp_address_ff;
   assign rsp_chan.command     = rsp_command_ff;

   always_comb begin
      scaled0   = CMP_W'(s1_first_ticks_ff) * CMP_W'(US_PER_10US);
      scaled1   = CMP_W'(s1_second_ticks_ff) * CMP_W'(US_PER_10US);
      levels_ok = (s1_first_level_ff == active_level_ff) &&
                  (s1_second_level_ff != active_level_ff);
      hdr_ok    = levels_ok && near_target(scaled0, HDR_MARK_US, margin_ff) &&
                  near_target(scaled1, HDR_SPACE_US, margin_ff);
      one_ok    = levels_ok && near_target(scaled0, BIT_MARK_US, margin_ff) &&
                  near_target(scaled1, ONE_SPACE_US, margin_ff);
      zero_ok   = levels_ok && near_target(scaled0, BIT_MARK_US, margin_ff) &&
                  near_target(scaled1, ZERO_SPACE_US, margin_ff);
      bit_val   = one_ok;

      in_header = (pos_ff == POS_HEADER);
      in_bits   = (pos_ff != POS_HEADER) && (pos_ff <= POS_LAST_BIT);
      in_addr   = (pos_ff <= POS_LAST_ADDR);
      addr_idx  = BIT_IDX_W'(pos_ff - POS_W'(1));
      cmd_idx   = BIT_IDX_W'(pos_ff - POS_FIRST_CMD);

      if (in_header) begin
         item_err = !hdr_ok;
      end else if (in_bits) begin
         item_err = !(one_ok || zero_ok);
      end else begin
         item_err = 1'b0;
      end

      addr_next = addr_ff;
      cmd_next  = cmd_ff;
      if (in_bits && in_addr) begin
         addr_next[addr_idx] = addr_ff[addr_idx] | bit_val;
      end else if (in_bits) begin
         cmd_next[cmd_idx] = cmd_ff[cmd_idx] | bit_val;
      end
      err_next = err_ff || item_err;
      pos_next = (pos_ff < FRAME_ITEMS) ? pos_ff + POS_W'(1) : pos_ff;
      frame_ok = (pos_next >= FRAME_ITEMS) && !err_next;

      pos_in  = pos_ff;
      addr_in = addr_ff;
      cmd_in  = cmd_ff;
      err_in  = err_ff;
      if (s1_fire && s1_last_ff) begin
         pos_in  = '0;
         addr_in = '0;
         cmd_in  = '0;
         err_in  = 1'b0;
      end else if (s1_fire) begin
         pos_in  = pos_next;
         addr_in = addr_next;
         cmd_in  = cmd_next;
         err_in  = err_next;
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      active_level_in = active_level_ff;
      margin_in       = margin_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_ACTIVE_LEVEL: active_level_in = csr_write_data[0];
            CSR_TOLERANCE:    margin_in       = csr_write_data;
            default: begin
               active_level_in = active_level_ff;
               margin_in       = margin_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_level_ff <= ACTIVE_LEVEL_RESET;
         margin_ff       <= TOLERANCE_RESET;
         s1_valid_ff     <= 1'b0;
         pos_ff          <= '0;
         addr_ff         <= '0;
         cmd_ff          <= '0;
         err_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         active_level_ff <= active_level_in;
         margin_ff       <= margin_in;
         s1_valid_ff     <= s1_valid_in;
         pos_ff          <= pos_in;
         addr_ff         <= addr_in;
         cmd_ff          <= cmd_in;
         err_ff          <= err_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_first_level_ff  <= req_chan.first_level;
         s1_first_ticks_ff  <= req_chan.first_ticks;
         s1_second_level_ff <= req_chan.second_level;
         s1_second_ticks_ff <= req_chan.second_ticks;
         s1_last_ff         <= req_chan.last_item;
      end
      if (rsp_load) begin
         rsp_frame_valid_ff <= frame_ok;
         rsp_address_ff     <= frame_ok ? addr_next : '0;
         rsp_command_ff     <= frame_ok ? cmd_next : '0;
      end
   end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the NEC infrared frame decoder. Pulse items are fed
// from a queue under random sender and receiver stalls, an item-level decoder
// model predicts every frame item and the monitor compares each field. Runs
// directed frames first, then random frames, corrupt, short and noisy buffers
// under several level and margin settings.
// ----------------------------------------------------------------------------
module tb_top;
   import nirfd_pkg::*;

   localparam int unsigned TICKS_PER_10US    = 8;
   localparam int unsigned ITEMS_PER_SETTING = 200;
   localparam int unsigned SETTING_COUNT     = 7;
   localparam int unsigned CYCLE_LIMIT       = 400000;
   localparam int unsigned MAX_TICKS         = 32767;

   typedef struct packed {
      logic               first_level;
      logic [TICKS_W-1:0] first_ticks;
      logic               second_level;
      logic [TICKS_W-1:0] second_ticks;
      logic               last_item;
   } pulse_item_type;

   typedef struct packed {
      logic              frame_valid;
      logic [WORD_W-1:0] address;
      logic [WORD_W-1:0] command;
   } frame_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;

   nirfd_req_if req_chan ();
   nirfd_rsp_if rsp_chan ();

   nec_ir_frame_decoder_core #(.TICKS_PER_10US(TICKS_PER_10US)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   pulse_item_type pending_pulses[$];
   pulse_item_type buffer_build[$];
   frame_item_type expected_frames[$];
   pulse_item_type next_pulse;
   pulse_item_type seen_pulse;
   frame_item_type seen_frame;
   frame_item_type want_frame;

   // decoder model state and register copies
   bit                   cfg_active_level = ACTIVE_LEVEL_RESET;
   int unsigned          cfg_tolerance    = 32'(TOLERANCE_RESET);
   logic [POS_W-1:0]     frame_pos        = '0;
   logic [WORD_W-1:0]    frame_address    = '0;
   logic [WORD_W-1:0]    frame_command    = '0;
   bit                   frame_error      = 1'b0;

   int unsigned send_idle_pct = 27;
   int unsigned recv_idle_pct = 67;
   int unsigned error_count   = 0;
   int unsigned cycle_count   = 0;
   int unsigned items_added   = 0;

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      if (error_count < 50)
         $display("mismatch: %s expected 0x%0h got 0x%0h at cycle %0d",
                  what, want, got, cycle_count);
      error_count++;
   endtask

   function automatic bit near_target(input int unsigned dur, input int unsigned target);
      return (dur < target + cfg_tolerance) && (dur + cfg_tolerance > target);
   endfunction

   function automatic void decode_pulse(input pulse_item_type p);
      int unsigned mark_us;
      int unsigned space_us;
      bit          levels_ok;
      bit          bit_value;
      frame_item_type result;
      mark_us   = (32'(p.first_ticks) * 10) / TICKS_PER_10US;
      space_us  = (32'(p.second_ticks) * 10) / TICKS_PER_10US;
      levels_ok = (p.first_level == cfg_active_level) && (p.second_level != cfg_active_level);
      if (frame_pos == POS_HEADER) begin
         if (!(levels_ok && near_target(mark_us, HDR_MARK_US)
               && near_target(space_us, HDR_SPACE_US)))
            frame_error = 1'b1;
      end else if (frame_pos <= POS_LAST_BIT) begin
         bit_value = 1'b0;
         if (levels_ok && near_target(mark_us, BIT_MARK_US)
             && near_target(space_us, ONE_SPACE_US))
            bit_value = 1'b1;
         else if (!(levels_ok && near_target(mark_us, BIT_MARK_US)
                    && near_target(space_us, ZERO_SPACE_US)))
            frame_error = 1'b1;
         if (frame_pos <= POS_LAST_ADDR)
            frame_address[frame_pos - 1] = bit_value;
         else
            frame_command[frame_pos - POS_FIRST_CMD] = bit_value;
      end
      if (frame_pos < FRAME_ITEMS)
         frame_pos = frame_pos + 1;
      if (p.last_item) begin
         if (frame_pos >= FRAME_ITEMS && !frame_error)
            result = '{1'b1, frame_address, frame_command};
         else
            result = '{1'b0, '0, '0};
         expected_frames.push_back(result);
         frame_pos     = '0;
         frame_address = '0;
         frame_command = '0;
         frame_error   = 1'b0;
      end
   endfunction

   // smallest tick count whose duration is at least the given time
   function automatic logic [TICKS_W-1:0] us_ticks(input int us);
      int unsigned t;
      if (us <= 0)
         return '0;
      t = (us * TICKS_PER_10US + 9) / 10;
      if (t > MAX_TICKS)
         t = MAX_TICKS;
      return t[TICKS_W-1:0];
   endfunction

   function automatic pulse_item_type make_pulse(input int unsigned mark_us,
                                                 input int unsigned space_us,
                                                 input int unsigned jitter);
      pulse_item_type p;
      int             mark_off;
      int             space_off;
      mark_off  = int'($urandom_range(2 * jitter)) - int'(jitter);
      space_off = int'($urandom_range(2 * jitter)) - int'(jitter);
      p.first_level  = cfg_active_level;
      p.second_level = ~cfg_active_level;
      p.first_ticks  = us_ticks(int'(mark_us) + mark_off);
      p.second_ticks = us_ticks(int'(space_us) + space_off);
      p.last_item    = 1'b0;
      return p;
   endfunction

   function automatic pulse_item_type noise_pulse();
      pulse_item_type p;
      p.first_level  = 1'($urandom_range(1));
      p.first_ticks  = 15'($urandom_range(MAX_TICKS));
      p.second_level = 1'($urandom_range(1));
      p.second_ticks = 15'($urandom_range(MAX_TICKS));
      p.last_item    = 1'b0;
      return p;
   endfunction

   task automatic build_frame(input logic [WORD_W-1:0] addr, input logic [WORD_W-1:0] cmd,
                              input int unsigned jitter);
      logic [2*WORD_W-1:0] bits;
      bits = {cmd, addr};
      buffer_build.delete();
      buffer_build.push_back(make_pulse(HDR_MARK_US, HDR_SPACE_US, jitter));
      for (int i = 0; i < 2 * WORD_W; i++)
         buffer_build.push_back(make_pulse(BIT_MARK_US,
                                bits[i] ? ONE_SPACE_US : ZERO_SPACE_US, jitter));
   endtask

   task automatic add_noise(input int unsigned n);
      repeat (n) buffer_build.push_back(noise_pulse());
   endtask

   // marks the final item of the buffer and queues the whole buffer
   task automatic commit_buffer();
      foreach (buffer_build[i]) begin
         buffer_build[i].last_item = (i == buffer_build.size() - 1);
         pending_pulses.push_back(buffer_build[i]);
      end
      items_added += buffer_build.size();
      buffer_build.delete();
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      if (idx == CSR_ACTIVE_LEVEL)
         cfg_active_level = data[0];
      else
         cfg_tolerance = 32'(data);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_pulses.size() != 0 || req_chan.valid || expected_frames.size() != 0);
      repeat (6) @(negedge clock);
   endtask

   task automatic random_buffer();
      int unsigned kind;
      int unsigned jitter;
      int unsigned idx;
      int unsigned keep;
      kind = $urandom_range(99);
      case ($urandom_range(3))
         0:       jitter = 0;
         3:       jitter = cfg_tolerance + 3;
         default: jitter = (cfg_tolerance > 0) ? cfg_tolerance - 1 : 0;
      endcase
      if (kind < 84 || kind >= 92)
         build_frame(16'($urandom_range(16'hffff)), 16'($urandom_range(16'hffff)), jitter);
      if (kind < 62) begin
         add_noise($urandom_range(1, 3));
      end else if (kind < 74) begin
         idx = $urandom_range(POS_LAST_BIT);
         case ($urandom_range(2))
            0:       buffer_build[idx].first_level  = ~buffer_build[idx].first_level;
            1:       buffer_build[idx].second_level = cfg_active_level;
            default: buffer_build[idx].first_ticks  = 15'($urandom_range(MAX_TICKS));
         endcase
         add_noise($urandom_range(1, 2));
      end else if (kind < 84) begin
         keep = $urandom_range(1, FRAME_ITEMS - 1);
         while (buffer_build.size() > keep)
            void'(buffer_build.pop_back());
      end else if (kind < 92) begin
         add_noise($urandom_range(1, 40));
      end else begin
         add_noise($urandom_range(1, 6));
      end
      commit_buffer();
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (pending_pulses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_pulse = pending_pulses.pop_front();
            req_chan.first_level  <= next_pulse.first_level;
            req_chan.first_ticks  <= next_pulse.first_ticks;
            req_chan.second_level <= next_pulse.second_level;
            req_chan.second_ticks <= next_pulse.second_ticks;
            req_chan.last_item    <= next_pulse.last_item;
            req_chan.valid        <= 1'b1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            seen_pulse = '{req_chan.first_level, req_chan.first_ticks,
                           req_chan.second_level, req_chan.second_ticks, req_chan.last_item};
            decode_pulse(seen_pulse);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_frame = '{rsp_chan.frame_valid, rsp_chan.address, rsp_chan.command};
            if (expected_frames.size() == 0) begin
               report_mismatch("frame item with none pending", 0, 32'(seen_frame));
            end else begin
               want_frame = expected_frames.pop_front();
               if (seen_frame.frame_valid !== want_frame.frame_valid)
                  report_mismatch("frame_valid", 32'(want_frame.frame_valid),
                                  32'(seen_frame.frame_valid));
               if (seen_frame.address !== want_frame.address)
                  report_mismatch("address", 32'(want_frame.address),
                                  32'(seen_frame.address));
               if (seen_frame.command !== want_frame.command)
                  report_mismatch("command", 32'(want_frame.command),
                                  32'(seen_frame.command));
            end
         end
      end
   end

   initial begin
      bit          levels[SETTING_COUNT]  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      int unsigned margins[SETTING_COUNT] = '{20, 20, 0, 1000, 5, 600, 0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed buffers at reset settings
      buffer_build.push_back('{1'b0, '0, 1'b0, '0, 1'b0});
      commit_buffer();
      buffer_build.push_back('{1'b1, 15'h7fff, 1'b1, 15'h7fff, 1'b0});
      commit_buffer();
      build_frame(16'hffff, 16'h0000, 0);
      add_noise(1);
      commit_buffer();
      build_frame(16'h0000, 16'hffff, 0);
      add_noise(1);
      commit_buffer();
      // short buffer ending on the last data bit
      build_frame(16'h5a3c, 16'hc3a5, 0);
      commit_buffer();
      // header mark right on the upper bound
      build_frame(16'h1234, 16'h8765, 0);
      buffer_build[0].first_ticks = us_ticks(HDR_MARK_US + cfg_tolerance);
      add_noise(1);
      commit_buffer();
      // header mark just inside the lower bound
      build_frame(16'hbeef, 16'h0f0f, 0);
      buffer_build[0].first_ticks = us_ticks(HDR_MARK_US - cfg_tolerance + 1);
      add_noise(1);
      commit_buffer();
      wait_drained();

      for (int s = 0; s < SETTING_COUNT; s++) begin
         if (s < 2) begin
            send_idle_pct = 27;
            recv_idle_pct = 67;
         end else if (s < 4) begin
            send_idle_pct = 67;
            recv_idle_pct = 27;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_csr(CSR_ACTIVE_LEVEL, {9'($urandom_range(511)), levels[s]});
         write_csr(CSR_TOLERANCE, (s == SETTING_COUNT - 1) ? 10'($urandom_range(1, 1000))
                                                           : 10'(margins[s]));
         items_added = 0;
         while (items_added < ITEMS_PER_SETTING)
            random_buffer();
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (expected_frames.size() != 0)
         report_mismatch("frame items left over", 0, 32'(expected_frames.size()));
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
